### hw/rtl/rmaf_pkg.sv
// ----------------------------------------------------------------------------
// rmaf_pkg: shared types and constants of the receive address filter
// Item and result payloads, classified commands, configuration and codes.
// ----------------------------------------------------------------------------
package rmaf_pkg;

  localparam int ADDR_W    = 48;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;
  localparam int PDATA_W   = 64;

  // Input modes.
  localparam logic [1:0] MODE_RX_CHECK   = 2'd0;
  localparam logic [1:0] MODE_LOOPBACK   = 2'd1;
  localparam logic [1:0] MODE_MCAST_ADD  = 2'd2;
  localparam logic [1:0] MODE_MCAST_DEL  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_UNICAST   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BROADCAST = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOUND     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REMOVING  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PROMISC_P = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PROMISC_M = 3'd5;

  // Group bit position: bit 0 of the first octet.
  localparam int GROUP_BIT = ADDR_W - 8;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] unicast_addr;
    logic [ADDR_W-1:0] broadcast_addr;
    logic              bound;
    logic              removing;
    logic              promisc_phys;
    logic              promisc_multi;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_DECIDED,
    OP_LOOKUP,
    OP_ADD,
    OP_REMOVE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic              accepted;
    logic [ADDR_W-1:0] address;
  } cmd_t;

endpackage

### hw/rtl/rmaf_front.sv
// ----------------------------------------------------------------------------
// rmaf_front: item intake and classification
// Decides every item that needs no table access and turns the rest into
// lookup, add or remove commands for the table engine.
// ----------------------------------------------------------------------------
module rmaf_front import rmaf_pkg::*; #(
  parameter int ADDR_BYTES = 6
) (
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  cfg_t  cfg,
  input  logic  queue_full,
  output logic  push,
  output cmd_t  push_cmd
);

  localparam int CMP_OCTETS = (ADDR_BYTES > 6) ? 6 : ADDR_BYTES;
  localparam int CMP_BITS   = 8 * CMP_OCTETS;

  logic open_chan;
  logic ucast_hit;
  logic bcast_hit;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  assign open_chan = cfg.bound && !cfg.removing;
  assign ucast_hit = item.address[ADDR_W-1 -: CMP_BITS] == cfg.unicast_addr[ADDR_W-1 -: CMP_BITS];
  assign bcast_hit = item.address[ADDR_W-1 -: CMP_BITS] ==
                     cfg.broadcast_addr[ADDR_W-1 -: CMP_BITS];

  always_comb begin
    push_cmd.op       = OP_DECIDED;
    push_cmd.accepted = 1'b0;
    push_cmd.address  = item.address;
    case (item.mode)
      MODE_RX_CHECK: begin
        if (!open_chan) begin
          push_cmd.accepted = 1'b0;
        end else if (cfg.promisc_phys || ucast_hit) begin
          push_cmd.accepted = 1'b1;
        end else if (!item.address[GROUP_BIT]) begin
          push_cmd.accepted = 1'b0;
        end else if (bcast_hit || cfg.promisc_multi) begin
          push_cmd.accepted = 1'b1;
        end else begin
          push_cmd.op = OP_LOOKUP;
        end
      end
      MODE_LOOPBACK: begin
        push_cmd.accepted = open_chan && cfg.promisc_phys;
      end
      MODE_MCAST_ADD: begin
        push_cmd.op = OP_ADD;
      end
      default: begin
        push_cmd.op = OP_REMOVE;
      end
    endcase
  end

endmodule

### hw/rtl/rmaf_cmd_queue.sv
// ----------------------------------------------------------------------------
// rmaf_cmd_queue: two-entry command queue
// Parts the intake from the table engine so that each side stalls alone.
// ----------------------------------------------------------------------------
module rmaf_cmd_queue import rmaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hw/rtl/rmaf_table_engine.sv
// ----------------------------------------------------------------------------
// rmaf_table_engine: multicast table and result register
// Compares a command against every entry as it is popped; once the result
// register is free, resolves it, updates the table and loads that register.
// ----------------------------------------------------------------------------
module rmaf_table_engine import rmaf_pkg::*; #(
  parameter int MCAST_ENTRIES = 16,
  parameter int ADDR_BYTES    = 6
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    queue_empty,
  input  cmd_t    head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CMP_OCTETS = (ADDR_BYTES > 6) ? 6 : ADDR_BYTES;
  localparam int CMP_BITS   = 8 * CMP_OCTETS;

  typedef enum logic {
    S_MATCH,
    S_RESOLVE
  } state_t;

  state_t                   state;
  cmd_op_t                  cur_op;
  logic                     cur_acc;
  logic [CMP_BITS-1:0]      cur_key;
  logic [MCAST_ENTRIES-1:0] match;

  logic [CMP_BITS-1:0]      entry_key [MCAST_ENTRIES];
  logic [MCAST_ENTRIES-1:0] entry_valid;

  logic [CMP_BITS-1:0]      head_key;
  logic [MCAST_ENTRIES-1:0] match_next;
  logic [MCAST_ENTRIES-1:0] free;
  logic [MCAST_ENTRIES-1:0] free_first;
  logic                     hit;
  logic                     slot_open;
  logic                     resolve;
  result_t                  result_next;

  assign head_key = head.address[ADDR_W-1 -: CMP_BITS];
  assign pop      = (state == S_MATCH) && !queue_empty;
  assign slot_open = !result_valid || !result_stall;
  assign resolve  = (state == S_RESOLVE) && slot_open;

  always_comb begin
    for (int i = 0; i < MCAST_ENTRIES; i++) begin
      match_next[i] = entry_valid[i] && (entry_key[i] == head_key);
    end
  end

  // Entries are unique, so at most one bit of the match vector is set.
  assign hit        = |match;
  assign free       = ~entry_valid;
  assign free_first = free & (~free + MCAST_ENTRIES'(1));

  always_comb begin
    result_next.accepted = 1'b0;
    result_next.status   = STATUS_OK;
    case (cur_op)
      OP_DECIDED: result_next.accepted = cur_acc;
      OP_LOOKUP:  result_next.accepted = hit;
      OP_ADD: begin
        if (!hit && !(|free)) begin
          result_next.status = STATUS_FULL;
        end
      end
      default: begin
        if (!hit) begin
          result_next.status = STATUS_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_MATCH;
      result_valid <= 1'b0;
    end else begin
      if (resolve) begin
        result_valid <= 1'b1;
      end else if (slot_open) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_MATCH: begin
          if (pop) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (resolve) begin
            state <= S_MATCH;
          end
        end
        default: begin
          state <= S_MATCH;
        end
      endcase
    end
    if (pop) begin
      cur_op  <= head.op;
      cur_acc <= head.accepted;
      cur_key <= head_key;
      match   <= match_next;
    end
    if (resolve) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (resolve) begin
      if (cur_op == OP_ADD && !hit) begin
        entry_valid <= entry_valid | free_first;
      end else if (cur_op == OP_REMOVE) begin
        entry_valid <= entry_valid & ~match;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MCAST_ENTRIES; i++) begin
      if (resolve && cur_op == OP_ADD && !hit && free_first[i]) begin
        entry_key[i] <= cur_key;
      end
    end
  end

endmodule

### hw/rtl/rx_mac_address_filter.sv
// ----------------------------------------------------------------------------
// rx_mac_address_filter: receive destination-address filter
// Unicast, broadcast and promiscuous checks plus a multicast address table.
// ----------------------------------------------------------------------------
// Each item carries a mode and a 48-bit address and yields exactly one
// result. A receive check is decided by the station flags, the unicast and
// broadcast addresses, and, for group addresses, a lookup in the multicast
// table; a loopback check depends on the flags alone; add and remove edit the
// table and report a full table or a missing address. The intake classifies
// one item per cycle, while the queue is not full, into a two-entry command
// queue. The table engine behind it compares an item against every entry,
// then resolves it and updates the table, and finishes each item before it
// takes the next. The result sits in an output register, so the intake
// keeps taking items while a result waits, until the command queue is full.
// The table's valid bits clear in the reset cycle itself; there is no
// clearing pass. Addresses are compared over their first ADDR_BYTES octets
// (at most the six carried). Registers sit on the configuration port at byte
// address 8 * index, 64 bits wide, and may be written only while the block
// is idle.
// ----------------------------------------------------------------------------
module rx_mac_address_filter import rmaf_pkg::*; #(
  parameter int MCAST_ENTRIES = 16,
  parameter int ADDR_BYTES    = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_empty;
  logic pop;
  cmd_t head;

  // Registers are 64 bits apart, so the index starts at address bit 3.
  assign reg_idx   = paddr[PADDR_W-1:3];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unicast_addr   <= '0;
      cfg.broadcast_addr <= '1;
      cfg.bound          <= 1'b0;
      cfg.removing       <= 1'b0;
      cfg.promisc_phys   <= 1'b0;
      cfg.promisc_multi  <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_UNICAST:   cfg.unicast_addr   <= pwdata[ADDR_W-1:0];
        REG_BROADCAST: cfg.broadcast_addr <= pwdata[ADDR_W-1:0];
        REG_BOUND:     cfg.bound          <= pwdata[0];
        REG_REMOVING:  cfg.removing       <= pwdata[0];
        REG_PROMISC_P: cfg.promisc_phys   <= pwdata[0];
        REG_PROMISC_M: cfg.promisc_multi  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UNICAST:   prdata = {{(PDATA_W-ADDR_W){1'b0}}, cfg.unicast_addr};
      REG_BROADCAST: prdata = {{(PDATA_W-ADDR_W){1'b0}}, cfg.broadcast_addr};
      REG_BOUND:     prdata = {{(PDATA_W-1){1'b0}}, cfg.bound};
      REG_REMOVING:  prdata = {{(PDATA_W-1){1'b0}}, cfg.removing};
      REG_PROMISC_P: prdata = {{(PDATA_W-1){1'b0}}, cfg.promisc_phys};
      REG_PROMISC_M: prdata = {{(PDATA_W-1){1'b0}}, cfg.promisc_multi};
      default:       prdata = '0;
    endcase
  end

  // The intake settles every item that needs no table access and queues it
  // with its decision; only lookups, adds and removes touch the table.
  rmaf_front #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rmaf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  // The engine finishes one command before it pops the next, so every
  // command sees the table as the previous one left it.
  rmaf_table_engine #(
    .MCAST_ENTRIES (MCAST_ENTRIES),
    .ADDR_BYTES    (ADDR_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
